// File: src/dvrs_pkg.sv
// Shared types, constants and the frequency-to-voltage table of the DVFS voltage ramp sequencer.
// Used by every module of the block; depends on nothing.
package dvrs_pkg;

    localparam int MAX_COMMANDS = 32;
    localparam int QDEPTH       = 2;
    localparam int QPTR_W       = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W       = $clog2(QDEPTH + 1);

    localparam int PHASE_W = 2;
    localparam int KHZ_W   = 20;
    localparam int KIND_W  = 2;
    localparam int MV_W    = 12;
    localparam int STEP_W  = 10;
    localparam int DLY_W   = 5;
    localparam int DIST_W  = 10;
    localparam int COUNT_W = DIST_W + 1;
    localparam int CNT_W   = $clog2(MAX_COMMANDS + 1);
    localparam int DIVC_W  = $clog2(DIST_W + 1);

    localparam logic [PHASE_W-1:0] PHASE_PRE  = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_POST = 2'd1;

    localparam logic [KIND_W-1:0] KIND_CMD       = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NONE      = 2'd1;
    localparam logic [KIND_W-1:0] KIND_UNHANDLED = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TOO_LONG  = 2'd3;

    localparam logic [1:0] OP_DIRECT    = 2'd0;
    localparam logic [1:0] OP_NONE      = 2'd1;
    localparam logic [1:0] OP_UNHANDLED = 2'd2;
    localparam logic [1:0] OP_RAMP      = 2'd3;

    localparam logic [MV_W-1:0] MV_DEFAULT = 12'd1550;

    // One classified request as it travels from the front to the back.
    typedef struct packed {
        logic [1:0]        op;
        logic [MV_W-1:0]   mv;    // target level for direct, start level for a ramp
        logic [DIST_W-1:0] span;
        logic              up;
        logic [STEP_W-1:0] step;
        logic              de;
    } desc_t;

    function automatic logic [MV_W-1:0] lookup_mv(input logic [KHZ_W-1:0] khz);
        logic [MV_W-1:0] mv;
        unique case (khz)
            20'd104000: mv = 12'd900;
            20'd156000: mv = 12'd1050;
            20'd208000: mv = 12'd1100;
            20'd312000: mv = 12'd1250;
            20'd416000: mv = 12'd1350;
            20'd520000: mv = 12'd1450;
            20'd624000: mv = 12'd1550;
            default:    mv = MV_DEFAULT;
        endcase
        return mv;
    endfunction

endpackage

// File: src/dvfs_voltage_ramp_sequencer.sv
// Top level of the DVFS voltage ramp sequencer: configuration registers and the
// front end, request queue and command sequencer. Depends on dvrs_pkg and all dvrs_* modules.
//
// Usage: each request on the s_ channel describes one frequency transition: a phase
// (before or after the change) and the old and new frequencies in kHz. The block answers
// on the m_ channel with a run of results whose final one has m_tlast set: either one
// status result (nothing to do, unhandled phase, ramp too long), one direct voltage
// command when step_mv is zero, or a ramp of up to MAX_COMMANDS voltage commands.
// step_mv and command_delay are written over the APB port at byte addresses 0 and 4;
// the user must write them only while the block is idle; the block does not enforce this.
// A request that needs no ramp has its result written straight into the output register.
// A ramp first passes through the bit-serial divider that finds its length and the state
// that judges it; then one command leaves per cycle while the receiver accepts them.
// The divider and the one command per cycle set the rate.
// A two-entry queue lets the front take new requests while the sequencer is busy.
// Reset clears the registers to zero, empties the queue and drops m_tvalid.
// When the receiver stalls, the current result holds in the output register and the
// sequencer waits; once the queue fills, s_tready goes low.
module dvfs_voltage_ramp_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // old_khz [19:0], new_khz [39:20]
    input  logic [1:0]  s_tuser,   // phase [1:0]
    // Result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // millivolts [11:0], delay_enable [12], zero [15:13]
    output logic [1:0]  m_tuser,   // kind [1:0]
    output logic        m_tlast    // last
);
    import dvrs_pkg::*;

    localparam logic REG_STEP  = 1'b0;
    localparam logic REG_DELAY = 1'b1;

    logic [STEP_W-1:0] step_reg;
    logic [DLY_W-1:0]  delay_reg;
    logic              cfg_write;

    desc_t             front_desc;
    desc_t             q_data;
    logic              push;
    logic              pop;
    logic              q_full;
    logic              q_empty;
    logic [MV_W-1:0]   mv_out;
    logic              de_out;

    // The register index sits in the word-address bit; the byte offset bits are ignored.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= '0;
            delay_reg <= '0;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_STEP:  step_reg  <= pwdata[STEP_W-1:0];
                default:   delay_reg <= pwdata[DLY_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_STEP:  prdata = 32'(step_reg);
            default:   prdata = 32'(delay_reg);
        endcase
    end

    dvrs_front u_front (
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .phase         (s_tuser),
        .old_khz       (s_tdata[19:0]),
        .new_khz       (s_tdata[39:20]),
        .step_mv       (step_reg),
        .command_delay (delay_reg),
        .q_full        (q_full),
        .push          (push),
        .desc          (front_desc)
    );

    dvrs_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (front_desc),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (q_data),
        .empty     (q_empty)
    );

    dvrs_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_empty      (q_empty),
        .q_data       (q_data),
        .pop          (pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .kind         (m_tuser),
        .millivolts   (mv_out),
        .delay_enable (de_out),
        .last         (m_tlast)
    );

    assign m_tdata = {3'b000, de_out, mv_out};

endmodule

// File: src/dvrs_front.sv
// Front end: takes transition requests, looks up both voltages and classifies the request.
// Depends on dvrs_pkg.
module dvrs_front (
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [dvrs_pkg::PHASE_W-1:0]  phase,
    input  logic [dvrs_pkg::KHZ_W-1:0]    old_khz,
    input  logic [dvrs_pkg::KHZ_W-1:0]    new_khz,
    input  logic [dvrs_pkg::STEP_W-1:0]   step_mv,
    input  logic [dvrs_pkg::DLY_W-1:0]    command_delay,
    input  logic                          q_full,
    output logic                          push,
    output dvrs_pkg::desc_t               desc
);
    import dvrs_pkg::*;

    logic [MV_W-1:0] old_mv;
    logic [MV_W-1:0] new_mv;
    logic [MV_W-1:0] diff;
    logic            up;
    logic            wrong_dir;

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    assign old_mv    = lookup_mv(old_khz);
    assign new_mv    = lookup_mv(new_khz);
    assign up        = new_mv > old_mv;
    assign diff      = up ? (new_mv - old_mv) : (old_mv - new_mv);
    assign wrong_dir = ((phase == PHASE_PRE) && (new_khz < old_khz)) ||
                       ((phase == PHASE_POST) && (new_khz > old_khz));

    always_comb begin
        desc.mv   = old_mv;
        desc.span = diff[DIST_W-1:0];
        desc.up   = up;
        desc.step = step_mv;
        desc.de   = (command_delay != '0);
        priority if (phase != PHASE_PRE && phase != PHASE_POST) begin
            desc.op = OP_UNHANDLED;
        end else if (wrong_dir) begin
            desc.op = OP_NONE;
        end else if (step_mv == '0) begin
            desc.op = OP_DIRECT;
            desc.mv = new_mv;
        end else if (new_mv == old_mv) begin
            desc.op = OP_NONE;
        end else begin
            desc.op = OP_RAMP;
        end
    end

endmodule

// File: src/dvrs_fifo.sv
// Short request queue between the front end and the command sequencer.
// Depends on dvrs_pkg for the descriptor type and depth.
module dvrs_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  dvrs_pkg::desc_t push_data,
    output logic            full,
    input  logic            pop,
    output dvrs_pkg::desc_t pop_data,
    output logic            empty
);
    import dvrs_pkg::*;

    desc_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    assign full     = (count_reg == QCNT_W'(QDEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: src/dvrs_back.sv
// Back end: divides out ramp lengths and emits commands and status results via an output register.
// Depends on dvrs_pkg.
module dvrs_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         q_empty,
    input  dvrs_pkg::desc_t              q_data,
    output logic                         pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [dvrs_pkg::KIND_W-1:0]  kind,
    output logic [dvrs_pkg::MV_W-1:0]    millivolts,
    output logic                         delay_enable,
    output logic                         last
);
    import dvrs_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [DIST_W-1:0]  dvd_reg, dvd_next;
    logic [DIST_W-1:0]  rem_reg, rem_next;
    logic [DIST_W-1:0]  quo_reg, quo_next;
    logic [DIVC_W-1:0]  divc_reg, divc_next;
    logic [CNT_W-1:0]   emit_reg, emit_next;
    logic [MV_W-1:0]    mv_reg, mv_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               up_reg, up_next;
    logic               de_reg, de_next;

    logic               ovalid_reg, ovalid_next;
    logic [KIND_W-1:0]  okind_reg, okind_next;
    logic [MV_W-1:0]    omv_reg, omv_next;
    logic               ode_reg, ode_next;
    logic               olast_reg, olast_next;

    logic               out_free;
    logic [DIST_W:0]    trial;
    logic               ge;
    logic [COUNT_W-1:0] count;
    logic [MV_W-1:0]    mv_step;

    assign out_free = !ovalid_reg || m_tready;
    assign pop      = (state_reg == ST_IDLE) && !q_empty &&
                      ((q_data.op == OP_RAMP) || out_free);

    // One restoring division step a cycle.
    assign trial = {rem_reg, dvd_reg[DIST_W-1]};
    assign ge    = trial >= {1'b0, step_reg};
    // Upward ramps round the step count up, downward ramps round it down.
    assign count = {1'b0, quo_reg} + COUNT_W'(up_reg && (rem_reg != '0));
    assign mv_step = up_reg ? (mv_reg + MV_W'(step_reg)) : (mv_reg - MV_W'(step_reg));

    always_comb begin
        state_next  = state_reg;
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        divc_next   = divc_reg;
        emit_next   = emit_reg;
        mv_next     = mv_reg;
        step_next   = step_reg;
        up_next     = up_reg;
        de_next     = de_reg;
        ovalid_next = ovalid_reg && !m_tready;
        okind_next  = okind_reg;
        omv_next    = omv_reg;
        ode_next    = ode_reg;
        olast_next  = olast_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (pop) begin
                    mv_next   = q_data.mv;
                    step_next = q_data.step;
                    up_next   = q_data.up;
                    de_next   = q_data.de;
                    if (q_data.op == OP_RAMP) begin
                        dvd_next   = q_data.span;
                        rem_next   = '0;
                        quo_next   = '0;
                        divc_next  = DIVC_W'(DIST_W);
                        state_next = ST_DIV;
                    end else begin
                        ovalid_next = 1'b1;
                        omv_next    = '0;
                        ode_next    = 1'b0;
                        olast_next  = 1'b1;
                        unique case (q_data.op)
                            OP_DIRECT: begin
                                okind_next = KIND_CMD;
                                omv_next   = q_data.mv;
                            end
                            OP_NONE:      okind_next = KIND_NONE;
                            default:      okind_next = KIND_UNHANDLED;
                        endcase
                    end
                end
            end
            ST_DIV: begin
                rem_next  = ge ? DIST_W'(trial - {1'b0, step_reg}) : trial[DIST_W-1:0];
                dvd_next  = {dvd_reg[DIST_W-2:0], 1'b0};
                quo_next  = {quo_reg[DIST_W-2:0], ge};
                divc_next = divc_reg - 1'b1;
                if (divc_reg == DIVC_W'(1)) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (count == '0 || count > COUNT_W'(MAX_COMMANDS)) begin
                    if (out_free) begin
                        ovalid_next = 1'b1;
                        okind_next  = (count == '0) ? KIND_NONE : KIND_TOO_LONG;
                        omv_next    = '0;
                        ode_next    = 1'b0;
                        olast_next  = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end else begin
                    emit_next  = count[CNT_W-1:0];
                    state_next = ST_EMIT;
                end
            end
            default: begin
                if (out_free) begin
                    ovalid_next = 1'b1;
                    okind_next  = KIND_CMD;
                    omv_next    = mv_step;
                    ode_next    = de_reg;
                    olast_next  = (emit_reg == CNT_W'(1));
                    mv_next     = mv_step;
                    emit_next   = emit_reg - 1'b1;
                    if (emit_reg == CNT_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
            divc_reg   <= '0;
            emit_reg   <= '0;
        end else begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            divc_reg   <= divc_next;
            emit_reg   <= emit_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg   <= dvd_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        mv_reg    <= mv_next;
        step_reg  <= step_next;
        up_reg    <= up_next;
        de_reg    <= de_next;
        okind_reg <= okind_next;
        omv_reg   <= omv_next;
        ode_reg   <= ode_next;
        olast_reg <= olast_next;
    end

    assign m_tvalid     = ovalid_reg;
    assign kind         = okind_reg;
    assign millivolts   = omv_reg;
    assign delay_enable = ode_reg;
    assign last         = olast_reg;

    // A command run never starts with nothing left to send.
    a_emit_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT |-> emit_reg != '0)
        else $error("command run entered with zero commands left");

    // Every result other than a voltage command closes its request alone.
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        ovalid_reg && okind_reg != KIND_CMD |-> olast_reg && omv_reg == '0 && !ode_reg)
        else $error("status result carries payload or is not last");

    // The queue is only drained from idle.
    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> state_reg == ST_DIV || state_reg == ST_IDLE)
        else $error("request popped while a ramp was in progress");

    // The division runs exactly its fixed number of steps before the count is judged;
    // the judging state may then wait for the output register.
    a_div_len: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FIN && $past(state_reg) != ST_FIN |->
            $past(state_reg) == ST_DIV && $past(divc_reg) == DIVC_W'(1))
        else $error("ramp length judged before the division finished");

endmodule
